>>> hdl/kllp_pkg.sv
// kllp_pkg: shared types and codes for the keyed linked list pool
// no dependencies
package kllp_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_ADD,
    S_WALK,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;   // write empty code at clear pointer
    logic take_in;      // capture input beat
    logic do_add;       // allocate and link element
    logic walk_step;    // consume one element of the walk
    logic end_remove;   // last walk step; marks head empty on a remove
    logic send_single;  // load the one result beat of a walk-less item
    logic pop_out;      // output beat taken
  } kllp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic is_add;
    logic is_walk;      // remove or read of a valid list
    logic walk_last;    // current walk element is final
    logic out_full;
  } kllp_sts_t;

endpackage

>>> hdl/kllp_ctrl.sv
// kllp_ctrl: sequencing state machine for the list pool
// depends on kllp_pkg
module kllp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  kllp_pkg::kllp_sts_t sts,
  output kllp_pkg::kllp_cmd_t cmd
);

  kllp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kllp_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kllp_pkg::S_CLEAR: if (sts.clear_done) state_next = kllp_pkg::S_IDLE;
      kllp_pkg::S_IDLE: if (in_valid) state_next = kllp_pkg::S_HEAD;
      kllp_pkg::S_HEAD: begin
        if (sts.is_add) state_next = kllp_pkg::S_ADD;
        else if (sts.is_walk) state_next = kllp_pkg::S_WALK;
        else state_next = kllp_pkg::S_RESULT;
      end
      kllp_pkg::S_ADD: state_next = kllp_pkg::S_RESULT;
      kllp_pkg::S_WALK: begin
        if (!sts.out_full && sts.walk_last) state_next = kllp_pkg::S_RESULT;
      end
      kllp_pkg::S_RESULT: if (!sts.out_full) state_next = kllp_pkg::S_IDLE;
      default: state_next = kllp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    cmd.pop_out = out_ready;
    case (state)
      kllp_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      kllp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take_in = in_valid;
      end
      kllp_pkg::S_ADD: cmd.do_add = 1'b1;
      kllp_pkg::S_WALK: begin
        cmd.walk_step = !sts.out_full;
        cmd.end_remove = !sts.out_full && sts.walk_last;
      end
      kllp_pkg::S_RESULT: cmd.send_single = !sts.out_full && !sts.is_walk;
      default: ;
    endcase
  end

endmodule

>>> hdl/kllp_dp.sv
// kllp_dp: head table, element pool, free stack and result register
// depends on kllp_pkg
module kllp_dp #(
  parameter int POOL_DEPTH = 64,
  parameter int KEY_COUNT  = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_key,
  input  logic [31:0]         in_value,
  input  kllp_pkg::kllp_cmd_t cmd,
  output kllp_pkg::kllp_sts_t sts,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [31:0]         out_value,
  output logic                out_present,
  output logic                out_last
);

  localparam int KW = (KEY_COUNT > 256) ? 8 : ((KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1);
  localparam int PW = $clog2(POOL_DEPTH);
  localparam logic [6:0] EMPTY = 7'h40;

  logic [6:0]  head_mem  [KEY_COUNT];
  logic [31:0] val_mem   [POOL_DEPTH];
  logic [6:0]  next_mem  [POOL_DEPTH];
  logic [5:0]  free_mem  [POOL_DEPTH];

  logic [KW:0] clr_ptr;
  logic [1:0]  kind;
  logic [7:0]  key;
  logic [31:0] value;
  logic        key_ok;
  logic [6:0]  head_q;
  logic [6:0]  cur;
  logic [6:0]  free_count;
  logic [6:0]  fresh_count;
  logic [6:0]  steps;
  logic        phase;       // 1 after head read done
  logic [31:0] cur_val;
  logic [6:0]  cur_next;
  logic [5:0]  free_top;
  logic        walk_ok;
  logic        alloc_ok;
  logic        from_free;
  logic [6:0]  alloc_ref;

  always_comb key_ok = ({24'd0, key} < 32'(KEY_COUNT));

  function automatic logic is_link(input logic [6:0] r);
    return {25'd0, r} < 32'(POOL_DEPTH);
  endfunction

  // head table
  always_ff @(posedge clk) begin
    if (cmd.clear_step) head_mem[clr_ptr[KW-1:0]] <= EMPTY;
    else if (cmd.do_add && sts.is_add && alloc_ok) head_mem[key[KW-1:0]] <= alloc_ref;
    else if (cmd.end_remove && kind == kllp_pkg::KIND_REMOVE)
      head_mem[key[KW-1:0]] <= EMPTY;
    if (cmd.take_in) head_q <= head_mem[in_key[KW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (cmd.clear_step) clr_ptr <= clr_ptr + 1'b1;
  end

  logic [6:0] head_eff;
  assign head_eff = key_ok ? head_q : EMPTY;

  // allocation
  always_comb begin
    from_free = (free_count != 7'd0) && ({25'd0, free_count} <= 32'(POOL_DEPTH));
    alloc_ok  = key_ok && (from_free || ({25'd0, fresh_count} < 32'(POOL_DEPTH)));
    if (from_free) begin
      alloc_ref = ({26'd0, free_top} < 32'(POOL_DEPTH)) ? {1'b0, free_top} : 7'd0;
    end else begin
      alloc_ref = fresh_count;
    end
  end

  // free stack top read, registered at head stage
  always_ff @(posedge clk) begin
    if (cmd.take_in || !phase) free_top <= free_mem[PW'(free_count - 7'd1)];
  end

  // pool memories; walk element read registered
  always_ff @(posedge clk) begin
    if (cmd.do_add && alloc_ok) begin
      val_mem[alloc_ref[PW-1:0]]  <= value;
      next_mem[alloc_ref[PW-1:0]] <= is_link(head_eff) ? head_eff : EMPTY;
    end
    if (cmd.walk_step && kind == kllp_pkg::KIND_REMOVE &&
        ({25'd0, free_count} < 32'(POOL_DEPTH)))
      free_mem[free_count[PW-1:0]] <= cur[5:0];
  end

  logic [6:0] rd_addr;
  assign rd_addr = phase ? (cmd.walk_step ? cur_next : cur) : head_eff;
  always_ff @(posedge clk) begin
    cur_val  <= val_mem[rd_addr[PW-1:0]];
    cur_next <= next_mem[rd_addr[PW-1:0]];
  end

  // input capture and walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 1'b0;
      free_count  <= '0;
      fresh_count <= '0;
    end else begin
      if (cmd.take_in) phase <= 1'b0;
      else if (!phase) phase <= 1'b1;
      if (cmd.do_add && alloc_ok) begin
        if (from_free) free_count <= free_count - 7'd1;
        else fresh_count <= fresh_count + 7'd1;
      end
      if (cmd.walk_step && kind == kllp_pkg::KIND_REMOVE &&
          ({25'd0, free_count} < 32'(POOL_DEPTH)))
        free_count <= free_count + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      kind  <= in_kind;
      key   <= in_key;
      value <= in_value;
    end
    if (!phase && !cmd.take_in) begin
      cur   <= head_eff;
      steps <= 7'd0;
    end else if (cmd.walk_step) begin
      cur   <= cur_next;
      steps <= steps + 7'd1;
    end
  end

  assign walk_ok = is_link(head_eff);

  always_comb begin
    sts.clear_done = cmd.clear_step && (clr_ptr == (KW+1)'(KEY_COUNT - 1));
    sts.is_add     = (kind == kllp_pkg::KIND_ADD);
    sts.is_walk    = walk_ok &&
                     (kind == kllp_pkg::KIND_REMOVE || kind == kllp_pkg::KIND_READ);
    sts.walk_last  = !is_link(cur_next) ||
                     ({25'd0, steps} + 32'd1 >= 32'(POOL_DEPTH));
    sts.out_full   = out_valid && !cmd.pop_out;
  end

  // result register; final beat of walk-less kinds loaded in result state
  logic load_single;
  assign load_single = cmd.send_single;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.walk_step && kind == kllp_pkg::KIND_READ) begin
      out_valid <= 1'b1;
    end else if (load_single) begin
      out_valid <= 1'b1;
    end else if (cmd.walk_step && cmd.end_remove) begin
      out_valid <= 1'b1;
    end else if (cmd.pop_out) begin
      out_valid <= 1'b0;
    end
  end

  logic add_ok_q;
  always_ff @(posedge clk) begin
    if (cmd.do_add) add_ok_q <= alloc_ok;
    if (cmd.walk_step && kind == kllp_pkg::KIND_READ) begin
      out_status  <= kllp_pkg::ST_OK;
      out_value   <= cur_val;
      out_present <= 1'b0;
      out_last    <= sts.walk_last;
    end else if (cmd.walk_step && cmd.end_remove) begin
      out_status  <= kllp_pkg::ST_OK;
      out_value   <= '0;
      out_present <= 1'b0;
      out_last    <= 1'b1;
    end else if (load_single) begin
      out_value   <= '0;
      out_last    <= 1'b1;
      out_present <= (kind == kllp_pkg::KIND_QUERY) && walk_ok;
      if (kind == kllp_pkg::KIND_ADD)
        out_status <= add_ok_q ? kllp_pkg::ST_OK : kllp_pkg::ST_FULL;
      else if (kind == kllp_pkg::KIND_QUERY) out_status <= kllp_pkg::ST_OK;
      else out_status <= kllp_pkg::ST_EMPTY;
    end
  end

endmodule

>>> hdl/keyed_linked_list_pool.sv
// keyed_linked_list_pool: top level, joins controller and datapath
// depends on kllp_pkg, kllp_ctrl, kllp_dp
//
// usage: one input beat on s_axis carries kind in tuser, key and value in tdata
//   add     pushes the value at the head of the key's list, one result beat
//   remove  returns the list elements to the free stack, one result beat
//   read    gives one beat per element, newest first, last set on the final
//   query   one beat with present set if the list is nonempty
// an empty read or remove answers status empty; an add with no free element answers full
// throughput one item at a time: the next beat is taken only after the previous
//   item's final result beat is in the output register
// reset: after rst the head table is swept to empty for every key, with
//   s_axis_tready low; the pool starts fully fresh
// stall: a result waits in the output register while m_axis_tready is low
//   and the walk pauses until it is taken
module keyed_linked_list_pool #(
  parameter int POOL_DEPTH = 64,
  parameter int KEY_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key[7:0], item_value[39:8]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[1:0], out_value[33:2], present[34], pad
  output logic        m_axis_tlast
);

  kllp_pkg::kllp_cmd_t cmd;
  kllp_pkg::kllp_sts_t sts;
  logic [1:0]  status;
  logic [31:0] out_value;
  logic        present;

  kllp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kllp_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .KEY_COUNT  (KEY_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_kind     (s_axis_tuser),
    .in_key      (s_axis_tdata[7:0]),
    .in_value    (s_axis_tdata[39:8]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_status  (status),
    .out_value   (out_value),
    .out_present (present),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, present, out_value, status};

endmodule

>>> tb/keyed_linked_list_pool_tb.sv
`timescale 1ns / 1ps
// keyed_linked_list_pool_tb: self-checking bench for the keyed linked list pool
// depends on kllp_pkg and keyed_linked_list_pool; predicts every result beat
module keyed_linked_list_pool_tb;

  localparam int POOL = 64;
  localparam int KEYS = 256;
  localparam logic [6:0] NO_ELEM = 7'h40;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    kllp_pkg::status_t status;
    logic [31:0]       value;
    logic              present;
    logic              last;
  } pool_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  keyed_linked_list_pool #(.POOL_DEPTH(POOL), .KEY_COUNT(KEYS)) dut (.*);

  always #5 clk = ~clk;

  // predicted copy of the pool state
  logic [6:0]  head_tbl [KEYS];
  logic [31:0] elem_val [POOL];
  logic [6:0]  elem_nxt [POOL];
  logic [5:0]  free_stk [POOL];
  int          free_cnt;
  int          fresh_cnt;
  // shadow of list lengths, used to steer stimulus
  int          list_len [KEYS];

  pool_result_t expected_results[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  ready_hold = 0;
  bit  ready_busy = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_result(kllp_pkg::status_t st, logic [31:0] v, logic p,
                                      logic l);
    pool_result_t r;
    r.status = st; r.value = v; r.present = p; r.last = l;
    expected_results.push_back(r);
  endfunction

  // compute the expected beats of one item and update the predicted state
  function automatic void predict_pool(kllp_pkg::kind_t kind, logic [7:0] key,
                                       logic [31:0] v);
    logic [6:0] hd, cur;
    int e, n;
    hd = head_tbl[key];
    case (kind)
      kllp_pkg::KIND_ADD: begin
        if (free_cnt > 0) begin
          free_cnt--;
          e = free_stk[free_cnt];
        end else if (fresh_cnt < POOL) begin
          e = fresh_cnt;
          fresh_cnt++;
        end else begin
          push_result(kllp_pkg::ST_FULL, '0, 1'b0, 1'b1);
          return;
        end
        elem_val[e] = v;
        elem_nxt[e] = (hd < POOL) ? hd : NO_ELEM;
        head_tbl[key] = 7'(e);
        list_len[key]++;
        push_result(kllp_pkg::ST_OK, '0, 1'b0, 1'b1);
      end
      kllp_pkg::KIND_QUERY: push_result(kllp_pkg::ST_OK, '0, hd < POOL, 1'b1);
      default: begin
        if (hd >= POOL) begin
          push_result(kllp_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
        end else if (kind == kllp_pkg::KIND_REMOVE) begin
          cur = hd; n = 0;
          while (cur < POOL && n < POOL) begin
            if (free_cnt < POOL) begin
              free_stk[free_cnt] = cur[5:0];
              free_cnt++;
            end
            cur = elem_nxt[cur]; n++;
          end
          head_tbl[key] = NO_ELEM;
          list_len[key] = 0;
          push_result(kllp_pkg::ST_OK, '0, 1'b0, 1'b1);
        end else begin
          cur = hd; n = 0;
          while (cur < POOL && n < POOL) begin
            push_result(kllp_pkg::ST_OK, elem_val[cur], 1'b0,
                        !(elem_nxt[cur] < POOL) || n + 1 >= POOL);
            cur = elem_nxt[cur]; n++;
          end
        end
      end
    endcase
  endfunction

  // send one beat, predict it, then idle for a random gap
  task automatic send_item(kllp_pkg::kind_t kind, logic [7:0] key, logic [31:0] v);
    s_axis_tdata  <= {v, key};
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_pool(kind, key, v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    repeat (gap_len()) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver stalls at random, mostly short, now and then long
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold <= 0;
    end else if (!ready_busy) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      ready_hold <= gap_len();
    end
  end

  // result checker: oldest expectation against each accepted beat
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status exp %0d got %0d", want.status, m_axis_tdata[1:0]); errors++;
        end
        if (m_axis_tdata[33:2] !== want.value) begin
          $error("out_value exp %h got %h", want.value, m_axis_tdata[33:2]); errors++;
        end
        if (m_axis_tdata[34] !== want.present) begin
          $error("present exp %b got %b", want.present, m_axis_tdata[34]); errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last exp %b got %b", want.last, m_axis_tlast); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // directed: every kind, empty lists, extreme values and keys
  task automatic test_directed();
    send_item(kllp_pkg::KIND_QUERY,  8'd0,   32'h0);
    send_item(kllp_pkg::KIND_READ,   8'd0,   32'h0);
    send_item(kllp_pkg::KIND_REMOVE, 8'd255, 32'h0);
    send_item(kllp_pkg::KIND_ADD,    8'd0,   32'h8000_0000);
    send_item(kllp_pkg::KIND_ADD,    8'd0,   32'h7FFF_FFFF);
    send_item(kllp_pkg::KIND_ADD,    8'd0,   32'hFFFF_FFFF);
    send_item(kllp_pkg::KIND_ADD,    8'd255, 32'h0);
    send_item(kllp_pkg::KIND_QUERY,  8'd0,   32'h0);
    send_item(kllp_pkg::KIND_QUERY,  8'd255, 32'h0);
    send_item(kllp_pkg::KIND_READ,   8'd0,   32'h0);
    send_item(kllp_pkg::KIND_READ,   8'd255, 32'h0);
    send_item(kllp_pkg::KIND_REMOVE, 8'd0,   32'h0);
    send_item(kllp_pkg::KIND_READ,   8'd0,   32'h0);
    send_item(kllp_pkg::KIND_QUERY,  8'd0,   32'h0);
    // reuse from the free stack
    send_item(kllp_pkg::KIND_ADD,    8'd170, 32'h5555_AAAA);
    send_item(kllp_pkg::KIND_ADD,    8'd85,  32'hAAAA_5555);
    send_item(kllp_pkg::KIND_READ,   8'd170, 32'h0);
  endtask

  // fill the pool, check the full answer, then free it all
  task automatic test_pool_full();
    int k;
    k = 8'd7;
    while (fresh_cnt < POOL || free_cnt > 0)
      send_item(kllp_pkg::KIND_ADD, 8'(k), $urandom());
    send_item(kllp_pkg::KIND_ADD, 8'd9, $urandom());
    send_item(kllp_pkg::KIND_READ, 8'(k), 32'h0);
    for (int i = 0; i < KEYS; i++)
      if (list_len[i] > 0) send_item(kllp_pkg::KIND_REMOVE, 8'(i), 32'h0);
  endtask

  // random mix, keys from a small set so lists grow and get walked
  task automatic test_random(int count);
    kllp_pkg::kind_t kd;
    logic [7:0] key;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      kd = r < 45 ? kllp_pkg::KIND_ADD : r < 60 ? kllp_pkg::KIND_REMOVE :
           r < 85 ? kllp_pkg::KIND_READ : kllp_pkg::KIND_QUERY;
      key = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5) * 51);
      send_item(kd, key, $urandom());
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_full();
    ready_busy = 1'b1;
    test_random(30);
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < KEYS; i++) begin
      head_tbl[i] = NO_ELEM;
      list_len[i] = 0;
    end
    free_cnt = 0;
    fresh_cnt = 0;
  end

endmodule

>>> filelist.f
hdl/kllp_pkg.sv
hdl/kllp_ctrl.sv
hdl/kllp_dp.sv
hdl/keyed_linked_list_pool.sv
tb/keyed_linked_list_pool_tb.sv
